// ----- rtl/core/free_text_base42_decode_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Free-text base-42 decode unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FREE_TEXT_BASE42_DECODE_UNIT_DEFINES_SVH
`define FREE_TEXT_BASE42_DECODE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define FT42_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ft42 same-cycle check failed");

// Next-cycle implication, disabled in reset
`define FT42_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ft42 next-cycle check failed");

`endif

// ----- rtl/core/ft42_pkg.sv -----
// ----------------------------------------------------------------------------
// ft42_pkg
// Types, constants and helper functions of the base-42 free-text decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ft42_pkg;

    localparam int NUM_CHARS    = 13;
    localparam int PAYLOAD_BITS = 71;
    localparam int RADIX        = 42;

    localparam int HIGH_W  = 7;
    localparam int LOW_W   = 64;
    localparam int DIGIT_W = 6;
    localparam int CHUNK_W = 6;
    localparam int CODE_W  = 7;
    localparam int POS_W   = 4;

    localparam int CHUNK_COUNT = (PAYLOAD_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int SLOT_COUNT  = (NUM_CHARS > CHUNK_COUNT) ? NUM_CHARS : CHUNK_COUNT;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int FEED_W      = SLOT_COUNT * CHUNK_W;

    localparam int RECIP       = 1560;
    localparam int RECIP_SHIFT = 16;
    localparam int STEP_W      = DIGIT_W + CHUNK_W;
    localparam int PROD_W      = STEP_W + 11;

    typedef struct packed {
        logic [HIGH_W-1:0] payload_high;
        logic [LOW_W-1:0]  payload_low;
    } t_in_item;

    typedef struct packed {
        logic [DIGIT_W-1:0] char_index;
        logic [CODE_W-1:0]  char_code;
        logic [POS_W-1:0]   text_position;
        logic               last_char;
    } t_out_item;

    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [CHUNK_W-1:0] carry;
    } t_link;

    typedef struct packed {
        logic [CHUNK_W-1:0] q;
        logic [DIGIT_W-1:0] r;
    } t_divmod;

    // (hi * 64 + lo) / 42 and % 42 for hi below 42: reciprocal estimate, one fix-up
    function automatic t_divmod divmod_radix(input logic [DIGIT_W-1:0] hi,
                                             input logic [CHUNK_W-1:0] lo);
        logic [STEP_W-1:0]  v;
        logic [PROD_W-1:0]  p;
        logic [CHUNK_W-1:0] q0;
        logic [STEP_W-1:0]  r0;
        t_divmod            res;
        v   = {hi, lo};
        p   = PROD_W'(v) * PROD_W'(RECIP);
        q0  = p[RECIP_SHIFT +: CHUNK_W];
        r0  = STEP_W'(v - STEP_W'(q0) * STEP_W'(RADIX));
        if (r0 >= STEP_W'(RADIX)) begin
            res.q = CHUNK_W'(q0 + 1'b1);
            res.r = DIGIT_W'(r0 - STEP_W'(RADIX));
        end else begin
            res.q = q0;
            res.r = DIGIT_W'(r0);
        end
        return res;
    endfunction

    // Symbol set: space, 0-9, A-Z, + - . / ?
    function automatic logic [CODE_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] c;
        case (d) inside
            6'd0:        c = 7'h20;
            [6'd1:6'd10]: c = CODE_W'(d) + 7'd47;
            [6'd11:6'd36]: c = CODE_W'(d) + 7'd54;
            6'd37:       c = 7'h2B;
            6'd38:       c = 7'h2D;
            6'd39:       c = 7'h2E;
            6'd40:       c = 7'h2F;
            default:     c = 7'h3F;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ft42_cell.sv -----
// ----------------------------------------------------------------------------
// ft42_cell
// One base-42 digit of the conversion chain: digit = (digit*64 + carry-in) mod 42, carry-out = quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ft42_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  ft42_pkg::t_link                 i_link,
    output ft42_pkg::t_link                 o_link,
    output logic                            o_emit,
    output logic [ft42_pkg::DIGIT_W-1:0]    o_digit
);
    import ft42_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    t_link              r_link;
    t_link              n_link;
    logic [DIGIT_W-1:0] base;
    t_divmod            dm;

    always_comb begin
        base         = i_link.first ? '0 : r_digit;
        dm           = divmod_radix(base, i_link.carry);
        n_digit      = i_link.vld ? dm.r : r_digit;
        n_link.vld   = i_link.vld;
        n_link.first = i_link.first;
        n_link.last  = i_link.last;
        n_link.carry = dm.q;
    end

    assign o_emit  = i_adv & i_link.vld & i_link.last;
    assign o_digit = dm.r;
    assign o_link  = r_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else if (i_adv) begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_digit <= n_digit;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ft42_feed.sv -----
// ----------------------------------------------------------------------------
// ft42_feed
// Holds one payload and hands it to the chain six bits a slot, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ft42_feed (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  ft42_pkg::t_in_item  i_item,
    output logic                o_stall,
    output ft42_pkg::t_link     o_link
);
    import ft42_pkg::*;

    logic                     r_busy;
    logic                     n_busy;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        n_slot;
    logic [FEED_W-1:0]        r_shift;
    logic [FEED_W-1:0]        n_shift;
    logic [HIGH_W+LOW_W-1:0]  full;
    logic                     last_slot;
    logic                     accept;

    assign full      = {i_item.payload_high, i_item.payload_low};
    assign last_slot = (r_slot == SLOT_W'(SLOT_COUNT - 1));
    assign o_stall   = r_busy & ~(i_adv & last_slot);
    assign accept    = i_valid & ~o_stall;

    always_comb begin
        o_link.vld   = r_busy;
        o_link.first = (r_slot == '0);
        o_link.last  = last_slot;
        o_link.carry = r_shift[FEED_W-1 -: CHUNK_W];
    end

    always_comb begin
        n_busy  = r_busy;
        n_slot  = r_slot;
        n_shift = r_shift;
        if (i_adv && r_busy) begin
            n_shift = r_shift << CHUNK_W;
            n_slot  = SLOT_W'(r_slot + 1'b1);
            if (last_slot) begin
                n_busy = 1'b0;
            end
        end
        if (accept) begin
            n_busy  = 1'b1;
            n_slot  = '0;
            n_shift = FEED_W'(full[PAYLOAD_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

endmodule

`default_nettype wire

// ----- rtl/core/free_text_base42_decode_unit.sv -----
// ----------------------------------------------------------------------------
// free_text_base42_decode_unit
// Splits a 71-bit free-text payload into 13 base-42 characters, LSD first.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_payload (t_in_item)
// result    out        o_valid / i_stall    o_result  (t_out_item)
//
// A payload enters the feed register and goes into the cell chain six bits per
// cycle over 13 slots unless the result side stalls; the next payload is
// taken as the last slot of the one before goes in. Cell k finishes its digit
// as the last slot reaches it; characters leave one per cycle unless stalled.
// Reset clears the feed state, the chain's valid tags and the output valid bit.
// A stall with a result held freezes the chain and the feed's shifting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module free_text_base42_decode_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ft42_pkg::t_in_item    i_payload,
    output logic                  o_stall,
    output logic                  o_valid,
    output ft42_pkg::t_out_item   o_result,
    input  logic                  i_stall
);
    import ft42_pkg::*;

    t_link              link  [NUM_CHARS+1];
    logic               emit  [NUM_CHARS];
    logic [DIGIT_W-1:0] digit [NUM_CHARS];
    logic               adv;
    logic               any_emit;
    t_out_item          sel;
    logic               r_out_vld;
    t_out_item          r_out;

    assign adv = ~r_out_vld | ~i_stall;

    ft42_feed u_feed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_item  (i_payload),
        .o_stall (o_stall),
        .o_link  (link[0])
    );

    for (genvar g = 0; g < NUM_CHARS; g++) begin : g_cell
        ft42_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_link  (link[g]),
            .o_link  (link[g+1]),
            .o_emit  (emit[g]),
            .o_digit (digit[g])
        );
    end

    always_comb begin
        any_emit = 1'b0;
        sel      = '0;
        for (int k = 0; k < NUM_CHARS; k++) begin
            if (emit[k]) begin
                any_emit          = 1'b1;
                sel.char_index    = digit[k];
                sel.char_code     = char_of(digit[k]);
                sel.text_position = POS_W'(NUM_CHARS - 1 - k);
                sel.last_char     = (k == NUM_CHARS - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= any_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= sel;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/ft42_checker.sv -----
// ----------------------------------------------------------------------------
// ft42_checker
// Port-level checks on the result stream of the base-42 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "free_text_base42_decode_unit_defines.svh"

module ft42_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  ft42_pkg::t_out_item  o_result
);
    import ft42_pkg::*;

    `FT42_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result))

    `FT42_ASSERT_NOW(a_last_at_zero, i_clk, i_rst_n, o_valid, o_result.last_char == (o_result.text_position == '0))

    `FT42_ASSERT_NEXT(a_pos_countdown, i_clk, i_rst_n, o_valid && !i_stall && !o_result.last_char, o_valid && (o_result.text_position == $past(o_result.text_position) - 4'd1))

    `FT42_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, o_valid, o_result.char_index < DIGIT_W'(RADIX))

endmodule

bind free_text_base42_decode_unit ft42_checker u_ft42_checker (.*);

`default_nettype wire

// ----- sim/free_text_base42_decode_unit_tb.sv -----
// ----------------------------------------------------------------------------
// free_text_base42_decode_unit_tb
// Drives 71-bit payloads into the decoder and checks every character result
// against digits worked out here by repeated division by 42: index, ASCII
// code, text position and last flag. The first items are hand-picked
// (zero, all ones, the 42^13 boundary, every symbol). The rest are random.
// Both channels idle in random bursts. One long receiver hold-off and two
// drain pauses are included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module free_text_base42_decode_unit_tb;
    import ft42_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 40;
    localparam int QUIET_TAIL  = 30;
    localparam logic [8*RADIX-1:0] GLYPHS = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-./?";

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_payload;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_result;
    logic      i_stall;

    t_in_item  pend_payloads[$];
    bit        pend_drain[$];
    t_out_item char_q[$];

    int  total_items;
    int  n_in;
    int  err_cnt;
    int  quiet_cycles;
    int  tx_gap;
    int  rx_hold;
    bit  took_item;
    bit  long_hold_done;
    logic [PAYLOAD_BITS-1:0] wrap_value;

    free_text_base42_decode_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_payload (i_payload),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_stall   (i_stall)
    );

    always #10 i_clk = ~i_clk;

    task automatic split_base42(input t_in_item it);
        logic [PAYLOAD_BITS-1:0] rest;
        int unsigned             d;
        t_out_item               c;
        rest = {it.payload_high, it.payload_low};
        for (int k = 0; k < NUM_CHARS; k++) begin
            d               = int'(rest % PAYLOAD_BITS'(RADIX));
            rest            = rest / PAYLOAD_BITS'(RADIX);
            c.char_index    = DIGIT_W'(d);
            c.char_code     = GLYPHS[8*(RADIX-1-d) +: CODE_W];
            c.text_position = POS_W'(NUM_CHARS - 1 - k);
            c.last_char     = (k == NUM_CHARS - 1);
            char_q = {char_q, c};
        end
    endtask

    task automatic queue_payload(input logic [PAYLOAD_BITS-1:0] v, input bit drain);
        t_in_item it;
        it = v;
        pend_payloads = {pend_payloads, it};
        pend_drain    = {pend_drain, drain};
    endtask

    // digit k (least significant first) is (base + k) mod 42
    function automatic logic [PAYLOAD_BITS-1:0] from_digits(input int base);
        logic [PAYLOAD_BITS-1:0] v;
        v = '0;
        for (int k = NUM_CHARS - 1; k >= 0; k--) begin
            v = v * PAYLOAD_BITS'(RADIX) + PAYLOAD_BITS'((base + k) % RADIX);
        end
        return v;
    endfunction

    // accept items and check results
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                split_base42(i_payload);
                void'(pend_payloads.pop_front());
                void'(pend_drain.pop_front());
                took_item = 1'b1;
                n_in++;
            end
            if (o_valid && !i_stall) begin
                if (char_q.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual idx=%0d code=%0h pos=%0d last=%0b"},
                             $time, o_result.char_index, o_result.char_code,
                             o_result.text_position, o_result.last_char);
                    err_cnt++;
                end else begin
                    want = char_q.pop_front();
                    if (o_result.char_index !== want.char_index ||
                        o_result.char_code !== want.char_code ||
                        o_result.text_position !== want.text_position ||
                        o_result.last_char !== want.last_char) begin
                        $display({"%0t: expected idx=%0d code=%0h pos=%0d last=%0b, ",
                                  "actual idx=%0d code=%0h pos=%0d last=%0b"},
                                 $time, want.char_index, want.char_code,
                                 want.text_position, want.last_char,
                                 o_result.char_index, o_result.char_code,
                                 o_result.text_position, o_result.last_char);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !took_item) begin
            // hold
        end else begin
            took_item = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pend_payloads.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pend_drain[0] && char_q.size() != 0) begin
                i_valid <= 1'b0;
            end else if (n_in < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                tx_gap  = $urandom_range(0, 6);
                i_valid <= 1'b0;
            end else begin
                i_valid   <= 1'b1;
                i_payload <= pend_payloads[0];
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (!long_hold_done && n_in >= 40) begin
            long_hold_done = 1'b1;
            rx_hold        = LONG_HOLD - 1;
            i_stall        <= 1'b1;
        end else if (n_in < total_items - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [PAYLOAD_BITS-1:0] v;
        logic [95:0]             wide;
        int                      pick;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_payload = '0;

        wrap_value = 1;
        repeat (NUM_CHARS) wrap_value = wrap_value * PAYLOAD_BITS'(RADIX);

        queue_payload('0, 1'b0);
        queue_payload('1, 1'b0);
        queue_payload(PAYLOAD_BITS'(1), 1'b0);
        queue_payload(PAYLOAD_BITS'(RADIX - 1), 1'b0);
        queue_payload(PAYLOAD_BITS'(RADIX), 1'b0);
        queue_payload(wrap_value - 1, 1'b0);
        queue_payload(wrap_value, 1'b1);
        queue_payload(wrap_value + 1, 1'b0);
        queue_payload({1'b1, {(PAYLOAD_BITS-1){1'b0}}}, 1'b0);
        queue_payload({7'h01, 64'h0}, 1'b0);
        queue_payload({7'h00, 64'h8000_0000_0000_0000}, 1'b0);
        queue_payload({7'h00, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0);
        queue_payload({7'h55, 64'h5555_5555_5555_5555}, 1'b0);
        queue_payload({7'h2A, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0);
        for (int b = 0; b < RADIX; b += NUM_CHARS) begin
            queue_payload(from_digits(b), 1'b0);
        end

        for (int n = 0; n < 240; n++) begin
            wide = {$urandom, $urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                v = wide[PAYLOAD_BITS-1:0];
            end else if (pick < 75) begin
                v = PAYLOAD_BITS'(wide % {25'b0, wrap_value});
            end else if (pick < 85) begin
                v = PAYLOAD_BITS'($urandom_range(0, 4095));
            end else begin
                v = wrap_value + PAYLOAD_BITS'($urandom_range(0, 200)) - PAYLOAD_BITS'(100);
            end
            queue_payload(v, n == 130);
        end
        total_items = pend_payloads.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_payloads.size() != 0 || char_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
